@@ rtl/core/graph_property_prefetch_queue_unit_assert.svh @@
// Assertion macros used by the prefetch queue top level.
// Files that check their own logic include this header; it needs clk and rst_n in scope.
`ifndef GRAPH_PROPERTY_PREFETCH_QUEUE_UNIT_ASSERT_SVH
`define GRAPH_PROPERTY_PREFETCH_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gppq_pkg.sv @@
// Shared types and constants of the graph property prefetch queue.
// No dependencies; used by the address generator, the top level and the verification files.
package gppq_pkg;

    localparam int ADDR_W     = 48;
    localparam int TIME_W     = 48;
    localparam int ID_W       = 32;
    localparam int CORE_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Neighbour IDs index a bitmap: 64 vertices per 8-byte property word.
    localparam int ID_SHIFT    = 6;
    localparam int ENTRY_SHIFT = 3;
    localparam int WORD_BYTES  = 4;

    localparam logic CMD_TRAIN = 1'b0;
    localparam logic CMD_ISSUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PROPERTY_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROPERTY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_INTERVAL = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [CORE_W-1:0] core;
        logic [ID_W-1:0]   neighbour_id;
        logic              last_word;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] prefetch_addr;
        logic [CORE_W-1:0] dest_core;
        logic [TIME_W-1:0] ready_time;
    } rsp_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] aligned;
        logic [TIME_W-1:0] ready_time;
    } gen_t;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_ADDR    = 13'b0000000000010,
        ST_CHK     = 13'b0000000000100,
        ST_SC_RD   = 13'b0000000001000,
        ST_SC_CMP  = 13'b0000000010000,
        ST_PUSH    = 13'b0000000100000,
        ST_LAST    = 13'b0000001000000,
        ST_WK_RD   = 13'b0000010000000,
        ST_WK_EV   = 13'b0000100000000,
        ST_APP     = 13'b0001000000000,
        ST_ISS_RD  = 13'b0010000000000,
        ST_ISS_SEL = 13'b0100000000000,
        ST_ISS_OUT = 13'b1000000000000
    } state_t;

endpackage

@@ rtl/core/gppq_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic storage used by the prefetch queue top level; no package use.
module gppq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/gppq_addr_gen.sv @@
// Maps a neighbour ID to its line-aligned property address, filters it against
// the window and computes the ready time. Registered output; uses gppq_pkg.
module gppq_addr_gen #(
    parameter int LINE_BYTES = 64,
    parameter int PUSH_W     = 5
) (
    input  logic                              clk,
    input  logic [gppq_pkg::ADDR_W-1:0]       base,
    input  logic [gppq_pkg::ADDR_W-1:0]       limit,
    input  logic [gppq_pkg::INTERVAL_W-1:0]   interval,
    input  logic [gppq_pkg::ID_W-1:0]         id,
    input  logic [gppq_pkg::TIME_W-1:0]       now,
    input  logic [PUSH_W-1:0]                 pushed,
    output gppq_pkg::gen_t                    gen
);

    localparam int PROD_W = PUSH_W + gppq_pkg::INTERVAL_W;
    // LINE_BYTES is a power of two, so alignment is a mask.
    localparam logic [gppq_pkg::ADDR_W-1:0] LINE_MASK = gppq_pkg::ADDR_W'(LINE_BYTES - 1);

    logic [gppq_pkg::ADDR_W-1:0] offset;
    logic [gppq_pkg::ADDR_W-1:0] addr;
    logic [gppq_pkg::ADDR_W-1:0] aligned;
    logic [PROD_W-1:0]           step;

    always_comb
    begin
        offset  = gppq_pkg::ADDR_W'(id >> gppq_pkg::ID_SHIFT) << gppq_pkg::ENTRY_SHIFT;
        addr    = base + offset;
        aligned = addr & ~LINE_MASK;
        step    = PROD_W'(pushed) * PROD_W'(interval);
    end

    always_ff @(posedge clk)
    begin
        gen.ok         <= (addr >= base) && (addr < limit) && (aligned >= base);
        gen.aligned    <= aligned;
        gen.ready_time <= now + gppq_pkg::TIME_W'(step);
    end

endmodule

@@ rtl/core/graph_property_prefetch_queue_unit.sv @@
// Top level of the graph property prefetch queue: control sequencer and state memories.
// Uses gppq_pkg, gppq_ram, gppq_addr_gen and the assertion macro header.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | gppq_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall | gppq_pkg::rsp_t
//   cfg     | in        | cfg_write             | cfg_index, cfg_data
//
// A train transaction holds the input through ST_ADDR, ST_CHK, ST_PUSH for a new address,
// and ST_LAST, plus ST_SC_RD and ST_SC_CMP per kept address of the current line until a match
// (dedupe scan through the line memory). A last word that appends a priority entry adds ST_APP,
// and ST_WK_RD and ST_WK_EV per priority entry when the line dropped addresses (compaction walk of
// the order memory). An issue runs ST_ISS_RD, ST_ISS_SEL and ST_ISS_OUT, held while rsp is stalled.
// Reset clears counts, pointers and configuration at once; no clearing pass is needed.
// A waiting response does not block the next request; a second issue waits for rsp to drain.
module graph_property_prefetch_queue_unit #(
    parameter int NUM_CORES   = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int LINE_BYTES  = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gppq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gppq_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  gppq_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output gppq_pkg::rsp_t                    rsp
);

    localparam int CIDX_W      = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int QD_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QMEM_DEPTH  = NUM_CORES * QUEUE_DEPTH;
    localparam int QMEM_AW     = (QMEM_DEPTH > 1) ? $clog2(QMEM_DEPTH) : 1;
    localparam int ORDER_DEPTH = NUM_CORES * QUEUE_DEPTH;
    localparam int OAW         = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
    localparam int OLEN_W      = $clog2(ORDER_DEPTH + 1);
    localparam int SEEN_DEPTH  = LINE_BYTES / gppq_pkg::WORD_BYTES;
    localparam int SAW         = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int SCNT_W      = $clog2(SEEN_DEPTH + 1);
    localparam int OE_W        = CIDX_W + SCNT_W;
    localparam int QE_W        = gppq_pkg::ADDR_W + gppq_pkg::TIME_W;

    function automatic logic [QD_W-1:0] q_wrap(input logic [QD_W:0] v);
        q_wrap = (v >= (QD_W + 1)'(QUEUE_DEPTH)) ? QD_W'(v - (QD_W + 1)'(QUEUE_DEPTH))
                                                 : QD_W'(v);
    endfunction

    function automatic logic [OAW-1:0] o_wrap(input logic [OAW+1:0] v);
        o_wrap = (v >= (OAW + 2)'(ORDER_DEPTH)) ? OAW'(v - (OAW + 2)'(ORDER_DEPTH))
                                                : OAW'(v);
    endfunction

    function automatic logic [QMEM_AW-1:0] q_base(input logic [CIDX_W-1:0] c);
        q_base = QMEM_AW'(c) * QMEM_AW'(QUEUE_DEPTH);
    endfunction

    gppq_pkg::state_t state_reg, state_next;
    gppq_pkg::req_t   req_reg;

    logic [gppq_pkg::ADDR_W-1:0]     base_reg, limit_reg;
    logic [gppq_pkg::INTERVAL_W-1:0] interval_reg;

    logic [SCNT_W-1:0] line_pushed_reg, line_pushed_next;
    logic [SCNT_W-1:0] line_dropped_reg, line_dropped_next;
    logic [SCNT_W-1:0] scan_reg, scan_next;

    logic [QD_W-1:0]   qhead_reg [NUM_CORES];
    logic [QD_W-1:0]   qhead_next [NUM_CORES];
    logic [QCNT_W-1:0] qcount_reg [NUM_CORES];
    logic [QCNT_W-1:0] qcount_next [NUM_CORES];

    logic [OAW-1:0]    ohead_reg, ohead_next;
    logic [OLEN_W-1:0] olen_reg, olen_next;
    logic [OAW-1:0]    rp_reg, rp_next, wp_reg, wp_next;
    logic [OLEN_W-1:0] wk_i_reg, wk_i_next, kept_reg, kept_next;
    logic [SCNT_W-1:0] drops_reg, drops_next;

    logic [CIDX_W-1:0] iss_core_reg, iss_core_next;
    logic              iss_use_reg, iss_use_next;
    logic              iss_any_reg, iss_any_next;

    gppq_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Memory ports.
    logic              q_we, q_re;
    logic [QMEM_AW-1:0] q_waddr, q_raddr;
    logic [QE_W-1:0]   q_wdata, q_rdata;
    logic              s_we, s_re;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [gppq_pkg::ADDR_W-1:0] s_wdata, s_rdata;
    logic              o_we, o_re;
    logic [OAW-1:0]    o_waddr, o_raddr;
    logic [OE_W-1:0]   o_wdata, o_rdata;

    gppq_pkg::gen_t    gen;
    logic [CIDX_W-1:0] cidx;
    logic [CIDX_W-1:0] low_core;
    logic              any_ne;
    logic [CIDX_W-1:0] ent_core;
    logic [SCNT_W-1:0] ent_cnt;
    logic              head_ok;
    logic              q_full;
    logic [QD_W-1:0]   q_slot;
    logic              rsp_go;

    gppq_addr_gen #(
        .LINE_BYTES (LINE_BYTES),
        .PUSH_W     (SCNT_W)
    ) u_addr_gen (
        .clk      (clk),
        .base     (base_reg),
        .limit    (limit_reg),
        .interval (interval_reg),
        .id       (req_reg.neighbour_id),
        .now      (req_reg.now_time),
        .pushed   (line_pushed_reg),
        .gen      (gen)
    );

    gppq_ram #(.WIDTH(QE_W), .DEPTH(QMEM_DEPTH), .AW(QMEM_AW)) u_queue_mem (
        .clk (clk), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
        .re (q_re), .raddr (q_raddr), .rdata (q_rdata)
    );

    gppq_ram #(.WIDTH(gppq_pkg::ADDR_W), .DEPTH(SEEN_DEPTH), .AW(SAW)) u_seen_mem (
        .clk (clk), .we (s_we), .waddr (s_waddr), .wdata (s_wdata),
        .re (s_re), .raddr (s_raddr), .rdata (s_rdata)
    );

    gppq_ram #(.WIDTH(OE_W), .DEPTH(ORDER_DEPTH), .AW(OAW)) u_order_mem (
        .clk (clk), .we (o_we), .waddr (o_waddr), .wdata (o_wdata),
        .re (o_re), .raddr (o_raddr), .rdata (o_rdata)
    );

    assign req_stall = (state_reg != gppq_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cidx      = CIDX_W'(req_reg.core);
    assign ent_core  = o_rdata[OE_W-1:SCNT_W];
    assign ent_cnt   = o_rdata[SCNT_W-1:0];
    assign rsp_go    = !rsp_valid_reg || !rsp_stall;

    // Lowest-numbered core whose queue holds an address.
    always_comb
    begin
        low_core = '0;
        any_ne   = 1'b0;
        for (int k = NUM_CORES - 1; k >= 0; k--)
        begin
            if (qcount_reg[k] != '0)
            begin
                low_core = CIDX_W'(k);
                any_ne   = 1'b1;
            end
        end
    end

    always_comb
    begin
        head_ok = 1'b0;
        if ((olen_reg != '0) && (int'(ent_core) < NUM_CORES))
        begin
            head_ok = (qcount_reg[ent_core] != '0);
        end
    end

    always_comb
    begin
        q_full = (qcount_reg[cidx] == QCNT_W'(QUEUE_DEPTH));
        q_slot = q_full ? qhead_reg[cidx]
                        : q_wrap((QD_W + 1)'(qhead_reg[cidx]) + (QD_W + 1)'(qcount_reg[cidx]));
    end

    always_comb
    begin
        state_next        = state_reg;
        line_pushed_next  = line_pushed_reg;
        line_dropped_next = line_dropped_reg;
        scan_next         = scan_reg;
        qhead_next        = qhead_reg;
        qcount_next       = qcount_reg;
        ohead_next        = ohead_reg;
        olen_next         = olen_reg;
        rp_next           = rp_reg;
        wp_next           = wp_reg;
        wk_i_next         = wk_i_reg;
        kept_next         = kept_reg;
        drops_next        = drops_reg;
        iss_core_next     = iss_core_reg;
        iss_use_next      = iss_use_reg;
        iss_any_next      = iss_any_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;

        q_we = 1'b0; q_waddr = '0; q_wdata = {gen.aligned, gen.ready_time};
        q_re = 1'b0; q_raddr = '0;
        s_we = 1'b0; s_waddr = line_pushed_reg[SAW-1:0]; s_wdata = gen.aligned;
        s_re = 1'b0; s_raddr = scan_reg[SAW-1:0];
        o_we = 1'b0; o_waddr = '0; o_wdata = '0;
        o_re = 1'b0; o_raddr = '0;

        case (state_reg)
            gppq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.cmd == gppq_pkg::CMD_ISSUE)
                    begin
                        state_next = gppq_pkg::ST_ISS_RD;
                    end
                    else if (int'(req.core) < NUM_CORES)
                    begin
                        state_next = gppq_pkg::ST_ADDR;
                    end
                end
            end
            gppq_pkg::ST_ADDR:
            begin
                state_next = gppq_pkg::ST_CHK;
            end
            gppq_pkg::ST_CHK:
            begin
                scan_next = '0;
                if (!gen.ok)
                begin
                    state_next = gppq_pkg::ST_LAST;
                end
                else if (line_pushed_reg == '0)
                begin
                    state_next = gppq_pkg::ST_PUSH;
                end
                else
                begin
                    state_next = gppq_pkg::ST_SC_RD;
                end
            end
            gppq_pkg::ST_SC_RD:
            begin
                s_re       = 1'b1;
                state_next = gppq_pkg::ST_SC_CMP;
            end
            gppq_pkg::ST_SC_CMP:
            begin
                if (s_rdata == gen.aligned)
                begin
                    state_next = gppq_pkg::ST_LAST;
                end
                else if (scan_reg + 1'b1 == line_pushed_reg)
                begin
                    state_next = gppq_pkg::ST_PUSH;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = gppq_pkg::ST_SC_RD;
                end
            end
            gppq_pkg::ST_PUSH:
            begin
                if (line_pushed_reg < SCNT_W'(SEEN_DEPTH))
                begin
                    s_we    = 1'b1;
                    q_we    = 1'b1;
                    q_waddr = q_base(cidx) + QMEM_AW'(q_slot);
                    // A full queue overwrites its oldest slot and moves the head past it.
                    if (q_full)
                    begin
                        qhead_next[cidx]  = q_wrap((QD_W + 1)'(qhead_reg[cidx]) + 1'b1);
                        line_dropped_next = line_dropped_reg + 1'b1;
                    end
                    else
                    begin
                        qcount_next[cidx] = qcount_reg[cidx] + 1'b1;
                    end
                    line_pushed_next = line_pushed_reg + 1'b1;
                end
                state_next = gppq_pkg::ST_LAST;
            end
            gppq_pkg::ST_LAST:
            begin
                rp_next    = ohead_reg;
                wp_next    = ohead_reg;
                wk_i_next  = '0;
                kept_next  = '0;
                drops_next = line_dropped_reg;
                if (!req_reg.last_word || (line_pushed_reg == '0))
                begin
                    state_next = gppq_pkg::ST_IDLE;
                end
                else if ((line_dropped_reg != '0) && (olen_reg != '0))
                begin
                    state_next = gppq_pkg::ST_WK_RD;
                end
                else
                begin
                    state_next = gppq_pkg::ST_APP;
                end
            end
            gppq_pkg::ST_WK_RD:
            begin
                o_re       = 1'b1;
                o_raddr    = rp_reg;
                state_next = gppq_pkg::ST_WK_EV;
            end
            gppq_pkg::ST_WK_EV:
            begin
                // Compacting walk: drops eat this core's oldest entries, the rest slide down.
                if ((ent_core == cidx) && (drops_reg != '0))
                begin
                    if (drops_reg < ent_cnt)
                    begin
                        o_we       = 1'b1;
                        o_waddr    = wp_reg;
                        o_wdata    = {ent_core, ent_cnt - drops_reg};
                        wp_next    = o_wrap((OAW + 2)'(wp_reg) + 1'b1);
                        kept_next  = kept_reg + 1'b1;
                        drops_next = '0;
                    end
                    else
                    begin
                        drops_next = drops_reg - ent_cnt;
                    end
                end
                else
                begin
                    o_we      = 1'b1;
                    o_waddr   = wp_reg;
                    o_wdata   = o_rdata;
                    wp_next   = o_wrap((OAW + 2)'(wp_reg) + 1'b1);
                    kept_next = kept_reg + 1'b1;
                end
                rp_next   = o_wrap((OAW + 2)'(rp_reg) + 1'b1);
                wk_i_next = wk_i_reg + 1'b1;
                if (wk_i_reg + 1'b1 == olen_reg)
                begin
                    olen_next  = kept_next;
                    state_next = gppq_pkg::ST_APP;
                end
                else
                begin
                    state_next = gppq_pkg::ST_WK_RD;
                end
            end
            gppq_pkg::ST_APP:
            begin
                if (olen_reg < OLEN_W'(ORDER_DEPTH))
                begin
                    o_we      = 1'b1;
                    o_waddr   = o_wrap((OAW + 2)'(ohead_reg) + (OAW + 2)'(olen_reg));
                    o_wdata   = {cidx, line_pushed_reg};
                    olen_next = olen_reg + 1'b1;
                end
                line_pushed_next  = '0;
                line_dropped_next = '0;
                state_next        = gppq_pkg::ST_IDLE;
            end
            gppq_pkg::ST_ISS_RD:
            begin
                o_re       = 1'b1;
                o_raddr    = ohead_reg;
                state_next = gppq_pkg::ST_ISS_SEL;
            end
            gppq_pkg::ST_ISS_SEL:
            begin
                iss_any_next  = any_ne;
                iss_use_next  = head_ok;
                iss_core_next = head_ok ? ent_core : low_core;
                q_re          = 1'b1;
                q_raddr       = q_base(iss_core_next) + QMEM_AW'(qhead_reg[iss_core_next]);
                state_next    = gppq_pkg::ST_ISS_OUT;
            end
            gppq_pkg::ST_ISS_OUT:
            begin
                if (rsp_go)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (iss_any_reg)
                    begin
                        rsp_next.hit           = 1'b1;
                        rsp_next.prefetch_addr = q_rdata[QE_W-1:gppq_pkg::TIME_W];
                        rsp_next.dest_core     = gppq_pkg::CORE_W'(iss_core_reg);
                        rsp_next.ready_time    = q_rdata[gppq_pkg::TIME_W-1:0];
                        qhead_next[iss_core_reg] =
                            q_wrap((QD_W + 1)'(qhead_reg[iss_core_reg]) + 1'b1);
                        qcount_next[iss_core_reg] = qcount_reg[iss_core_reg] - 1'b1;
                        if (iss_use_reg)
                        begin
                            if (ent_cnt <= SCNT_W'(1))
                            begin
                                ohead_next = o_wrap((OAW + 2)'(ohead_reg) + 1'b1);
                                olen_next  = olen_reg - 1'b1;
                            end
                            else
                            begin
                                o_we    = 1'b1;
                                o_waddr = ohead_reg;
                                o_wdata = {ent_core, ent_cnt - 1'b1};
                            end
                        end
                    end
                    state_next = gppq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gppq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gppq_pkg::ST_IDLE;
            base_reg         <= '0;
            limit_reg        <= '0;
            interval_reg     <= '0;
            line_pushed_reg  <= '0;
            line_dropped_reg <= '0;
            scan_reg         <= '0;
            ohead_reg        <= '0;
            olen_reg         <= '0;
            rp_reg           <= '0;
            wp_reg           <= '0;
            wk_i_reg         <= '0;
            kept_reg         <= '0;
            drops_reg        <= '0;
            iss_core_reg     <= '0;
            iss_use_reg      <= 1'b0;
            iss_any_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            for (int k = 0; k < NUM_CORES; k++)
            begin
                qhead_reg[k]  <= '0;
                qcount_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            line_pushed_reg  <= line_pushed_next;
            line_dropped_reg <= line_dropped_next;
            scan_reg         <= scan_next;
            ohead_reg        <= ohead_next;
            olen_reg         <= olen_next;
            rp_reg           <= rp_next;
            wp_reg           <= wp_next;
            wk_i_reg         <= wk_i_next;
            kept_reg         <= kept_next;
            drops_reg        <= drops_next;
            iss_core_reg     <= iss_core_next;
            iss_use_reg      <= iss_use_next;
            iss_any_reg      <= iss_any_next;
            rsp_valid_reg    <= rsp_valid_next;
            qhead_reg        <= qhead_next;
            qcount_reg       <= qcount_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    gppq_pkg::CFG_PROPERTY_BASE:  base_reg     <= cfg_data;
                    gppq_pkg::CFG_PROPERTY_LIMIT: limit_reg    <= cfg_data;
                    gppq_pkg::CFG_ISSUE_INTERVAL:
                        interval_reg <= cfg_data[gppq_pkg::INTERVAL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == gppq_pkg::ST_IDLE) && req_valid)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

`include "graph_property_prefetch_queue_unit_assert.svh"

    `GPPQ_ASSERT_IMP(a_order_bound, 1'b1, olen_reg <= OLEN_W'(ORDER_DEPTH), "order length overflow")
    `GPPQ_ASSERT_IMP(a_drop_le_push, 1'b1, line_dropped_reg <= line_pushed_reg, "drops exceed pushes")
    `GPPQ_ASSERT_NXT(a_rsp_load, (state_reg == gppq_pkg::ST_ISS_OUT) && rsp_go, rsp_valid_reg, "issue lost")
    `GPPQ_ASSERT_NXT(a_line_clear, state_reg == gppq_pkg::ST_APP, line_pushed_reg == '0, "line not cleared")

endmodule

@@ verif/gppq_checker.sv @@
// Checker for the graph property prefetch queue: watches the cfg, req and rsp channels,
// predicts every response and compares it field by field. Depends on gppq_pkg.
module gppq_checker #(
    parameter int NUM_CORES   = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int LINE_BYTES  = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gppq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gppq_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  gppq_pkg::req_t                 req,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  gppq_pkg::rsp_t                 rsp,
    output int                             fail_count,
    output int                             pending
);
    localparam int SEEN_MAX  = LINE_BYTES / gppq_pkg::WORD_BYTES;
    localparam int ORDER_MAX = NUM_CORES * QUEUE_DEPTH;

    logic [gppq_pkg::ADDR_W-1:0]     win_base;
    logic [gppq_pkg::ADDR_W-1:0]     win_limit;
    logic [gppq_pkg::INTERVAL_W-1:0] interval;

    logic [gppq_pkg::ADDR_W-1:0] fifo_addr[NUM_CORES][QUEUE_DEPTH];
    logic [gppq_pkg::TIME_W-1:0] fifo_time[NUM_CORES][QUEUE_DEPTH];
    int                          fifo_fill[NUM_CORES];
    int                          prio_core[$];
    int                          prio_cnt[$];
    logic [gppq_pkg::ADDR_W-1:0] line_addrs[$];
    int                          line_drops;
    gppq_pkg::rsp_t              expected_rsp[$];

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: rsp %s got %h expected %h", $time, field, got, want);
        fail_count++;
    endtask

    task automatic fifo_pop(input int c);
        for (int i = 1; i < fifo_fill[c]; i++)
        begin
            fifo_addr[c][i-1] = fifo_addr[c][i];
            fifo_time[c][i-1] = fifo_time[c][i];
        end
        if (fifo_fill[c] > 0)
            fifo_fill[c]--;
    endtask

    task automatic charge_drops(input int c, input int drops);
        int i;
        i = 0;
        while (i < prio_core.size() && drops > 0)
        begin
            if (prio_core[i] == c && drops < prio_cnt[i])
            begin
                prio_cnt[i] -= drops;
                drops = 0;
            end
            else if (prio_core[i] == c)
            begin
                drops -= prio_cnt[i];
                prio_core.delete(i);
                prio_cnt.delete(i);
                continue;
            end
            i++;
        end
    endtask

    task automatic train_word(input gppq_pkg::req_t r);
        logic [gppq_pkg::ADDR_W-1:0] addr;
        logic [gppq_pkg::ADDR_W-1:0] aligned;
        logic [gppq_pkg::TIME_W-1:0] ready;
        bit                          seen;
        int                          c;
        c       = r.core;
        addr    = win_base + ({16'd0, r.neighbour_id} >> gppq_pkg::ID_SHIFT
                              << gppq_pkg::ENTRY_SHIFT);
        aligned = addr & ~gppq_pkg::ADDR_W'(LINE_BYTES - 1);
        seen    = 0;
        foreach (line_addrs[i])
            if (line_addrs[i] == aligned)
                seen = 1;
        if (addr >= win_base && addr < win_limit && aligned >= win_base && !seen
                && line_addrs.size() < SEEN_MAX)
        begin
            ready = r.now_time + gppq_pkg::TIME_W'(line_addrs.size())
                                 * gppq_pkg::TIME_W'(interval);
            line_addrs.insert(line_addrs.size(), aligned);
            if (fifo_fill[c] >= QUEUE_DEPTH)
            begin
                fifo_pop(c);
                line_drops++;
            end
            fifo_addr[c][fifo_fill[c]] = aligned;
            fifo_time[c][fifo_fill[c]] = ready;
            fifo_fill[c]++;
        end
        if (r.last_word)
        begin
            if (line_addrs.size() > 0)
            begin
                charge_drops(c, line_drops);
                if (prio_core.size() < ORDER_MAX)
                begin
                    prio_core.insert(prio_core.size(), c);
                    prio_cnt.insert(prio_cnt.size(), line_addrs.size());
                end
            end
            line_addrs.delete();
            line_drops = 0;
        end
    endtask

    task automatic issue_next();
        gppq_pkg::rsp_t r;
        int             d;
        bit             by_order;
        r = '0;
        d = -1;
        for (int c = NUM_CORES - 1; c >= 0; c--)
            if (fifo_fill[c] > 0)
                d = c;
        if (d >= 0)
        begin
            by_order = prio_core.size() > 0 && fifo_fill[prio_core[0]] > 0;
            if (by_order)
                d = prio_core[0];
            r.hit           = 1'b1;
            r.prefetch_addr = fifo_addr[d][0];
            r.dest_core     = gppq_pkg::CORE_W'(d);
            r.ready_time    = fifo_time[d][0];
            fifo_pop(d);
            if (by_order && prio_cnt[0] <= 1)
            begin
                prio_core.delete(0);
                prio_cnt.delete(0);
            end
            else if (by_order)
            begin
                prio_cnt[0]--;
            end
        end
        expected_rsp.insert(expected_rsp.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gppq_pkg::rsp_t want;
        if (!rst_n)
        begin
            win_base   = '0;
            win_limit  = '0;
            interval   = '0;
            fifo_fill  = '{default: 0};
            line_drops = 0;
            prio_core.delete();
            prio_cnt.delete();
            line_addrs.delete();
            expected_rsp.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    report("unexpected", 64'(rsp.prefetch_addr), 64'd0);
                end
                else
                begin
                    want = expected_rsp[0];
                    expected_rsp.delete(0);
                    if (rsp.hit !== want.hit)
                        report("hit", 64'(rsp.hit), 64'(want.hit));
                    if (rsp.prefetch_addr !== want.prefetch_addr)
                        report("prefetch_addr", 64'(rsp.prefetch_addr),
                               64'(want.prefetch_addr));
                    if (rsp.dest_core !== want.dest_core)
                        report("dest_core", 64'(rsp.dest_core), 64'(want.dest_core));
                    if (rsp.ready_time !== want.ready_time)
                        report("ready_time", 64'(rsp.ready_time), 64'(want.ready_time));
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    gppq_pkg::CFG_PROPERTY_BASE:  win_base = cfg_data;
                    gppq_pkg::CFG_PROPERTY_LIMIT: win_limit = cfg_data;
                    gppq_pkg::CFG_ISSUE_INTERVAL:
                        interval = cfg_data[gppq_pkg::INTERVAL_W-1:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                if (req.cmd == gppq_pkg::CMD_ISSUE)
                    issue_next();
                else if (int'(req.core) < NUM_CORES)
                    train_word(req);
            end
            pending = expected_rsp.size();
        end
    end
endmodule

@@ verif/tb.sv @@
// Testbench top for graph_property_prefetch_queue_unit: drives config, train and issue
// transactions with random idling and stalls. Depends on gppq_pkg and gppq_checker.
module tb;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [gppq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gppq_pkg::ADDR_W-1:0]    cfg_data = '0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    gppq_pkg::req_t                 req = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    gppq_pkg::rsp_t                 rsp;
    int                             fail_count;
    int                             pending;

    int                             send_idle_pct = 0;
    int                             stall_pct = 0;
    int                             hold_req = 0;
    int                             hold_done = 0;
    logic [gppq_pkg::ADDR_W-1:0]    span = 48'h2000;

    always #5 clk = ~clk;

    graph_property_prefetch_queue_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    gppq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    // The receiver stalls at random; a long hold-off is counted here in cycles.
    always @(posedge clk)
    begin
        if (hold_req != hold_done)
        begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clk);
            hold_done <= hold_req;
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send(input gppq_pkg::req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic send_word(input logic [gppq_pkg::CORE_W-1:0] c,
                             input logic [gppq_pkg::ID_W-1:0] id,
                             input logic last, input logic [gppq_pkg::TIME_W-1:0] t);
        gppq_pkg::req_t item;
        item.cmd          = gppq_pkg::CMD_TRAIN;
        item.core         = c;
        item.neighbour_id = id;
        item.last_word    = last;
        item.now_time     = t;
        send(item);
    endtask

    task automatic send_issue();
        gppq_pkg::req_t item;
        logic [95:0]    noise;
        noise    = {$urandom, $urandom, $urandom};
        item     = gppq_pkg::req_t'(noise[$bits(gppq_pkg::req_t)-1:0]);
        item.cmd = gppq_pkg::CMD_ISSUE;
        send(item);
    endtask

    // Waits for the block to drain before touching a register.
    task automatic set_window(input logic [gppq_pkg::ADDR_W-1:0] b,
                              input logic [gppq_pkg::ADDR_W-1:0] lim,
                              input logic [gppq_pkg::INTERVAL_W-1:0] gap);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= gppq_pkg::CFG_PROPERTY_BASE;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= gppq_pkg::CFG_PROPERTY_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= gppq_pkg::CFG_ISSUE_INTERVAL;
        cfg_data  <= gppq_pkg::ADDR_W'(gap);
        @(posedge clk);
        cfg_write <= 1'b0;
        span = lim - b;
    endtask

    // A neighbour ID that mostly lands in a few lines of the window, so dedupe hits.
    function automatic logic [gppq_pkg::ID_W-1:0] pick_id();
        logic [gppq_pkg::ID_W-1:0] entry;
        if ($urandom_range(9) == 0)
            return $urandom;
        entry = (span > 48'h40000) ? gppq_pkg::ID_W'($urandom_range(255))
                : gppq_pkg::ID_W'($urandom_range(int'(span[20:0] >> 3) + 8));
        return (entry << gppq_pkg::ID_SHIFT) | gppq_pkg::ID_W'($urandom_range(63));
    endfunction

    task automatic train_line(output int words);
        logic [gppq_pkg::CORE_W-1:0] c;
        logic [gppq_pkg::TIME_W-1:0] t;
        int                          n;
        c = gppq_pkg::CORE_W'($urandom);
        t = gppq_pkg::TIME_W'({$urandom, $urandom});
        n = $urandom_range(20, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                c = gppq_pkg::CORE_W'($urandom);
            send_word(c, pick_id(), (i == n - 1) || ($urandom_range(29) == 0), t);
        end
        words = n;
    endtask

    initial
    begin
        int done;
        int words;
        int quota;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: miss on empty, ID and time extremes, wrap, core change, no-keep line.
        send_issue();
        set_window(48'h1000, 48'h9000, 16'hFFFF);
        send_word(3'd0, 32'h0, 1'b0, 48'hFFFF_FFFF_FFFF);
        send_word(3'd0, 32'h0000_003F, 1'b0, 48'h0);
        send_word(3'd0, 32'h0000_1000, 1'b1, 48'hFFFF_FFFF_FFF0);
        send_word(3'd7, 32'hFFFF_FFFF, 1'b1, 48'h1234);
        send_word(3'd5, 32'h0000_0400, 1'b0, 48'h55);
        send_word(3'd6, 32'h0000_0800, 1'b1, 48'h66);
        for (int i = 0; i < 6; i++)
            send_issue();
        set_window(48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FFFF, 16'd0);
        send_word(3'd2, 32'h0000_0000, 1'b0, 48'h10);
        send_word(3'd2, 32'hFFFF_FFFF, 1'b1, 48'h20);
        send_issue();
        send_issue();
        set_window(48'h0, 48'h0, 16'd1);
        send_word(3'd1, 32'h0000_0040, 1'b1, 48'h30);
        send_issue();

        done = 19;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            case (phase)
                0: set_window(48'h4000, 48'h6000, 16'd3);
                1: set_window(48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
                2: set_window(48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_FFFF, 16'd0);
                3: set_window(gppq_pkg::ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_0000,
                              48'hFFFF_FFFF_FFFF, gppq_pkg::INTERVAL_W'($urandom));
                4: set_window(48'h8_0000, 48'h8_0800, 16'd1);
                5: set_window(48'h1000, 48'h1000, gppq_pkg::INTERVAL_W'($urandom));
                6: set_window(48'h0, 48'h4_0000, gppq_pkg::INTERVAL_W'($urandom));
                default: set_window(48'h1_0000, 48'h1_4000, 16'hFFFF);
            endcase
            if (phase == 2)
            begin
                // Responses back up while issues keep coming, so the input stalls.
                hold_req++;
                for (int i = 0; i < 30; i++)
                    send_issue();
                done += 30;
            end
            quota = (phase == 7) ? 1950 : done + 240;
            while (done < quota)
            begin
                if ($urandom_range(99) < 35)
                begin
                    send_issue();
                    done++;
                end
                else if (phase == 4 && $urandom_range(3) == 0)
                begin
                    // Many short lines with no issues fill the priority order.
                    for (int i = 0; i < 40; i++)
                        send_word(gppq_pkg::CORE_W'($urandom), pick_id(), 1'b1,
                                  gppq_pkg::TIME_W'({$urandom, $urandom}));
                    done += 40;
                end
                else
                begin
                    train_line(words);
                    done += words;
                end
            end
        end

        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ graph_property_prefetch_queue_unit.f @@
+incdir+rtl/core
rtl/core/gppq_pkg.sv
rtl/core/gppq_ram.sv
rtl/core/gppq_addr_gen.sv
rtl/core/graph_property_prefetch_queue_unit.sv
verif/gppq_checker.sv
verif/tb.sv
